// ===== hw/rtl/ceiling_priority_mutex_macros.svh =====
// Assertion macros used by the mutex RTL.
// Each macro takes a label, an antecedent and a consequent, and samples on
// clk with the synchronous reset rst disabling the check.
`ifndef CEILING_PRIORITY_MUTEX_MACROS_SVH
`define CEILING_PRIORITY_MUTEX_MACROS_SVH

// Same-cycle implication.
`define CPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpm: same-cycle check failed");

// Next-cycle implication.
`define CPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpm: next-cycle check failed");

`endif

// ===== hw/rtl/cpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_pkg
// Types and constants of the priority ceiling mutex.
// ----------------------------------------------------------------------------
package cpm_pkg;

  localparam int MAX_TASKS   = 16;
  localparam int PRIO_LEVELS = 16;
  localparam int ID_W        = 4;
  localparam int PRIO_W      = 4;
  localparam int PTR_W       = $clog2(MAX_TASKS);
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);

  localparam logic [PRIO_W-1:0] PRIO_RESET = PRIO_W'(PRIO_LEVELS - 1);

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ACT_GRANTED  = 3'd0,
    ACT_QUEUED   = 3'd1,
    ACT_OWNER    = 3'd2,
    ACT_RELEASED = 3'd3,
    ACT_HANDOFF  = 3'd4,
    ACT_OVERFLOW = 3'd5
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_prio;
  } req_t;

  typedef struct packed {
    action_t           action;
    logic [ID_W-1:0]   owner_task;
    logic [PRIO_W-1:0] owner_prio;
    logic [ID_W-1:0]   restored_task;
    logic [PRIO_W-1:0] restored_prio;
    logic              locked;
    logic [CNT_W-1:0]  waiters;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } waiter_t;

endpackage

// ===== hw/rtl/ceiling_priority_mutex.sv =====
// A request accepted at a clock edge is captured in req_q, and its result is loaded
// when the execute cycle completes. A new request is not taken until the last one is
// through, since each request reads the queue head before it updates state.
// Reset (rst, synchronous, active high) frees the mutex, empties the queue and
// sets the ceiling to 0; the waiter memory is not cleared and needs no sweep.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceiling_priority_mutex
// Hardware mutex under the immediate priority ceiling rule, with a FIFO of
// waiting tasks kept in a synchronous memory.
// ----------------------------------------------------------------------------
module ceiling_priority_mutex
  import cpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  // Result channel.
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  // Ceiling register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [PRIO_W-1:0] cfg_data
);

  // Control state. The mutex owner, its saved priority and the queue
  // pointers live in flops; the waiters themselves live in the memory.
  state_t            state, state_next;
  logic [PRIO_W-1:0] ceiling;
  logic              held;
  logic [ID_W-1:0]   owner;
  logic [PRIO_W-1:0] saved_prio;
  logic [PTR_W-1:0]  head_ptr;
  logic [PTR_W-1:0]  tail_ptr;
  logic [CNT_W-1:0]  wait_count;

  // Request captured at the transfer, used in the execute cycle.
  req_t              req_q;

  // Waiter memory: one write port at the tail, one registered read port at
  // the head.
  waiter_t           wait_mem [MAX_TASKS];
  waiter_t           head_rd;
  logic              mem_rd_en;
  logic              mem_wr_en;
  waiter_t           mem_wr_data;

  // Execute-cycle results.
  logic              held_next;
  logic [ID_W-1:0]   owner_next;
  logic [PRIO_W-1:0] saved_prio_next;
  logic [PTR_W-1:0]  head_ptr_next;
  logic [PTR_W-1:0]  tail_ptr_next;
  logic [CNT_W-1:0]  wait_count_next;
  rsp_t              rsp_next;
  logic              out_free;
  logic              exec_fire;
  logic              req_xfer;

  // The ceiling register takes a write in any cycle; the user must write it
  // only while the block is idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling <= '0;
    end else if (cfg_valid && cfg_ready) begin
      ceiling <= cfg_data;
    end
  end

  // A request is taken only in IDLE, so the head read and the update of the
  // execute cycle never overlap with the next request. The result register
  // lets one request be taken while the consumer stalls; its execute cycle waits.
  assign req_stall = (state != ST_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign exec_fire = (state == ST_EXEC) && out_free;
  assign mem_rd_en = req_xfer;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_q <= req;
    end
  end

  // Memory ports. The read of the head is issued at the transfer and its
  // data stays in head_rd until the next transfer.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      wait_mem[tail_ptr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      head_rd <= wait_mem[head_ptr];
    end
  end

  // Execute: decide the action, update owner and queue, build the result.
  always_comb begin
    held_next       = held;
    owner_next      = owner;
    saved_prio_next = saved_prio;
    head_ptr_next   = head_ptr;
    tail_ptr_next   = tail_ptr;
    wait_count_next = wait_count;
    mem_wr_en       = 1'b0;
    mem_wr_data     = '{id: req_q.task_id, prio: req_q.task_prio};
    rsp_next        = '0;

    if (req_q.op == OP_LOCK) begin
      if (!held) begin
        // Free mutex: grant it and remember the caller's own priority.
        held_next       = 1'b1;
        owner_next      = req_q.task_id;
        saved_prio_next = req_q.task_prio;
        rsp_next.action = ACT_GRANTED;
      end else if (req_q.task_id == owner) begin
        rsp_next.action = ACT_OWNER;
      end else if (wait_count == CNT_W'(MAX_TASKS)) begin
        rsp_next.action = ACT_OVERFLOW;
      end else begin
        // Join the tail; the priority is sampled now, not at hand-off.
        mem_wr_en       = exec_fire;
        tail_ptr_next   = (tail_ptr == PTR_W'(MAX_TASKS - 1)) ? '0 : tail_ptr + 1'b1;
        wait_count_next = wait_count + 1'b1;
        rsp_next.action = ACT_QUEUED;
      end
    end else begin
      // Any task may release; the request's id and priority play no part.
      rsp_next.action = ACT_RELEASED;
      if (held) begin
        rsp_next.restored_task = owner;
        rsp_next.restored_prio = saved_prio;
        held_next              = 1'b0;
        owner_next             = '0;
      end
      if (wait_count != '0) begin
        // Hand off to the head waiter read at the transfer.
        owner_next      = head_rd.id;
        saved_prio_next = head_rd.prio;
        head_ptr_next   = (head_ptr == PTR_W'(MAX_TASKS - 1)) ? '0 : head_ptr + 1'b1;
        wait_count_next = wait_count - 1'b1;
        held_next       = 1'b1;
        rsp_next.action = ACT_HANDOFF;
      end
    end

    rsp_next.locked  = held_next;
    rsp_next.waiters = wait_count_next;
    if (held_next) begin
      rsp_next.owner_task = owner_next;
      rsp_next.owner_prio = (saved_prio_next > ceiling) ? ceiling : saved_prio_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= 1'b0;
      owner      <= '0;
      saved_prio <= PRIO_RESET;
      head_ptr   <= '0;
      tail_ptr   <= '0;
      wait_count <= '0;
    end else if (exec_fire) begin
      held       <= held_next;
      owner      <= owner_next;
      saved_prio <= saved_prio_next;
      head_ptr   <= head_ptr_next;
      tail_ptr   <= tail_ptr_next;
      wait_count <= wait_count_next;
    end
  end

  // Result register: loaded when the execute cycle completes, held while
  // the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp <= rsp_next;
    end
  end

  // Checks on the block's own state.
  `include "ceiling_priority_mutex_macros.svh"

  // The queue never holds more than its depth.
  `CPM_ASSERT_NOW(a_count_bound, 1'b1, wait_count <= CNT_W'(MAX_TASKS))
  // Tasks wait only behind an owner.
  `CPM_ASSERT_NOW(a_free_means_empty, !held, wait_count == '0)
  // A transfer always leads into the execute cycle.
  `CPM_ASSERT_NEXT(a_xfer_to_exec, req_xfer, state == ST_EXEC)
  // A blocked execute cycle leaves the mutex state untouched.
  `CPM_ASSERT_NEXT(a_stall_holds, (state == ST_EXEC) && !out_free,
                   $stable(wait_count) && $stable(held) && $stable(owner))

endmodule

// ===== tb/ceiling_priority_mutex_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceiling_priority_mutex_tb
// Self-checking testbench for the priority ceiling mutex. A scoreboard
// class tracks ownership, the saved priority and the FIFO of waiters, and
// predicts one result per accepted request. Results are compared field by
// field, in order, against those predictions. Directed requests cover the
// corner cases. Random phases follow under planned ceilings; all but the third
// add random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module ceiling_priority_mutex_tb;
  import cpm_pkg::*;

  // Scoreboard: a shadow copy of the mutex state, with its pointers kept at the
  // block's own widths, plus the queue of results still expected from the block.
  class mutex_scoreboard;
    logic [PRIO_W-1:0] ceiling_q;
    logic              held;
    logic [ID_W-1:0]   owner;
    logic [PRIO_W-1:0] saved_prio;
    waiter_t           waitq [MAX_TASKS];
    logic [PTR_W-1:0]  head;
    logic [PTR_W-1:0]  tail;
    int                count;
    rsp_t              expected_rsp [$];
    int                errors;

    function new();
      ceiling_q  = '0;
      held       = 1'b0;
      owner      = '0;
      saved_prio = PRIO_RESET;
      head       = '0;
      tail       = '0;
      count      = 0;
      errors     = 0;
    endfunction

    function void set_ceiling(logic [PRIO_W-1:0] value);
      ceiling_q = value;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Applies one accepted request to the shadow state and queues the
    // result that the block must give for it.
    function void note_request(req_t r);
      rsp_t    e;
      waiter_t w;
      e = '0;
      if (r.op == OP_LOCK) begin
        if (!held) begin
          held       = 1'b1;
          owner      = r.task_id;
          saved_prio = r.task_prio;
          e.action   = ACT_GRANTED;
        end else if (r.task_id == owner) begin
          e.action = ACT_OWNER;
        end else if (count >= MAX_TASKS) begin
          e.action = ACT_OVERFLOW;
        end else begin
          w.id        = r.task_id;
          w.prio      = r.task_prio;
          waitq[tail] = w;
          tail++;
          count++;
          e.action = ACT_QUEUED;
        end
      end else begin
        // The requester's id and priority play no part in an unlock.
        e.action = ACT_RELEASED;
        if (held) begin
          e.restored_task = owner;
          e.restored_prio = saved_prio;
          held            = 1'b0;
          owner           = '0;
        end
        if (count > 0) begin
          owner      = waitq[head].id;
          saved_prio = waitq[head].prio;
          head++;
          count--;
          held     = 1'b1;
          e.action = ACT_HANDOFF;
        end
      end
      if (held) begin
        e.owner_task = owner;
        e.owner_prio = (saved_prio > ceiling_q) ? ceiling_q : saved_prio;
      end
      e.locked  = held;
      e.waiters = CNT_W'(count);
      expected_rsp.push_back(e);
    endfunction

    function void compare(string field, logic [7:0] exp, logic [7:0] act);
      if (exp !== act) begin
        errors++;
        $error("%s: expected %0d, got %0d", field, exp, act);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        errors++;
        $error("result with no request pending: action %0d", got.action);
        return;
      end
      e = expected_rsp.pop_front();
      compare("action", e.action, got.action);
      compare("owner_task", e.owner_task, got.owner_task);
      compare("owner_prio", e.owner_prio, got.owner_prio);
      compare("restored_task", e.restored_task, got.restored_task);
      compare("restored_prio", e.restored_prio, got.restored_prio);
      compare("locked", e.locked, got.locked);
      compare("waiters", e.waiters, got.waiters);
    endfunction
  endclass

  localparam int ITEMS_PER_PHASE = 75;
  localparam int NUM_PHASES      = 6;
  localparam int IDLE_LIMIT      = 2000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req       = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [PRIO_W-1:0] cfg_data  = '0;

  // When low, the request side sends back to back and, once a current burst ends,
  // the result side stops stalling, so stretches of full-rate traffic occur too.
  logic idle_en = 1'b0;

  mutex_scoreboard sb;
  int              stall_hold = 0;
  int              idle_cycles = 0;

  // The ceiling of each random phase; both extremes are visited, and the
  // mutex state carries over so that a held mutex sees its ceiling change.
  logic [PRIO_W-1:0] ceil_plan [NUM_PHASES] = '{4'd15, 4'd0, 4'd7, 4'd3, 4'd15, 4'd11};
  // Percentage of lock requests in each phase. A high share fills the queue
  // and drives it into overflow; a low share drains it and frees the mutex.
  int lock_bias [NUM_PHASES] = '{55, 85, 40, 60, 90, 30};

  ceiling_priority_mutex dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Length of an idle stretch: mostly drawn from the short range, now and then long.
  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int idle_gap();
    if (!idle_en || $urandom_range(0, 99) < 55) return 0;
    return gap_length();
  endfunction

  // Result-side back pressure. Stall bursts and open windows are drawn at random,
  // each held for a random number of cycles, so stalls land on both states of
  // the block's request handling.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (!idle_en) begin
      rsp_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 30) begin
      rsp_stall  <= 1'b1;
      stall_hold = gap_length();
    end else begin
      rsp_stall  <= 1'b0;
      stall_hold = $urandom_range(0, 5);
    end
  end

  // Every request and result transfer is observed at the clock edge at which it
  // happens. The request is noted before the result is checked, so a request and
  // the result it causes never race within one time step.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  // Watchdog: a run that stops moving for too long counts as hung.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** ceiling_priority_mutex: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(op_t op, int id, int prio);
    req_t r;
    r.op        = op;
    r.task_id   = ID_W'(id);
    r.task_prio = PRIO_W'(prio);
    return r;
  endfunction

  // A random request. Some locks reuse the current owner's id so that the
  // already-owner answer shows up regularly; ids come from a space of only
  // sixteen, so repeated waiters occur on their own.
  function automatic req_t random_req(int lock_pct);
    req_t r;
    r.op        = ($urandom_range(0, 99) < lock_pct) ? OP_LOCK : OP_UNLOCK;
    r.task_id   = ID_W'($urandom_range(0, 15));
    r.task_prio = PRIO_W'($urandom_range(0, 15));
    if (r.op == OP_LOCK && sb.held && $urandom_range(0, 9) < 2) r.task_id = sb.owner;
    return r;
  endfunction

  // Sends one request and returns at the edge of its transfer. Valid stays
  // high into the next request unless a gap is drawn, so back-to-back
  // traffic never lowers and raises valid within one time step.
  task automatic send_req(input req_t item);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
  endtask

  // Waits for the block to drain, then for the request's latency, so that
  // nothing is in flight when the result expected last has arrived.
  task automatic drain();
    req_valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // The ceiling is only written while the block is idle.
  task automatic write_ceiling(input logic [PRIO_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_ceiling(value);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst     <= 1'b0;
    idle_en <= 1'b1;

    // A mid-range ceiling, so that both sides of the cap are exercised.
    write_ceiling(4'd8);

    // Unlock of a free mutex with nobody waiting releases nothing.
    send_req(make_req(OP_UNLOCK, 15, 15));
    send_req(make_req(OP_LOCK, 0, 15));
    // A lock by the owner changes nothing.
    send_req(make_req(OP_LOCK, 0, 0));
    send_req(make_req(OP_LOCK, 15, 0));
    // The same task locking again while it waits is queued a second time.
    send_req(make_req(OP_LOCK, 15, 15));
    // Any task may release the mutex; both queued copies get handed it.
    send_req(make_req(OP_UNLOCK, 9, 4));
    send_req(make_req(OP_UNLOCK, 15, 0));
    send_req(make_req(OP_UNLOCK, 15, 15));
    send_req(make_req(OP_UNLOCK, 0, 0));

    // Fill the queue to its depth, then one lock more overflows it, while a
    // lock by the owner on a full queue is still just the owner's no-op.
    send_req(make_req(OP_LOCK, 3, 7));
    for (int i = 0; i < MAX_TASKS; i++) begin
      send_req(make_req(OP_LOCK, (i == 3) ? 14 : i, 15 - i));
    end
    send_req(make_req(OP_LOCK, 5, 0));
    send_req(make_req(OP_LOCK, 3, 0));

    // Random phases. The mutex state carries over from one phase to the
    // next, so the ceiling changes while the mutex is held and the queue is
    // in use. The third phase runs at full rate on both sides.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_ceiling(ceil_plan[p]);
      idle_en <= (p != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_req(random_req(lock_bias[p]));
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("** ceiling_priority_mutex: PASSED **");
    end else begin
      $display("** ceiling_priority_mutex: FAILED **");
    end
    $finish;
  end

endmodule
